### rtl/slma_pkg.sv
// Shared types, sizes and the reciprocal table for the slew-limited moving average.
// No dependencies; every other file of the block but slma_ram imports this package.
package slma_pkg;

   localparam int WINDOW      = 8;
   localparam int DATA_W      = 16;
   localparam int SUM_W       = DATA_W + $clog2(WINDOW);
   localparam int CNT_W       = $clog2(WINDOW + 1);
   localparam int SLOT_W      = $clog2(WINDOW);
   localparam int RECIP_SHIFT = SUM_W + CNT_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int NUM_W       = RECIP_W + 1;
   localparam int REM_W       = CNT_W + 1;

   localparam logic [CNT_W-1:0]  WINDOW_CNT     = CNT_W'(WINDOW);
   localparam logic [SLOT_W-1:0] LAST_SLOT      = SLOT_W'(WINDOW - 1);
   localparam logic [DATA_W-1:0] MAX_STEP_RESET = {DATA_W{1'b1}};

   // Sequencing commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic limit_en;
      logic update_en;
      logic mult_en;
      logic load;
   } slma_cmd_type;

   typedef logic [WINDOW:0][RECIP_W-1:0] recip_table_type;

   // Entry d holds ceil(2^RECIP_SHIFT / d). With RECIP_SHIFT = SUM_W + CNT_W the
   // error term stays below one, so the shifted product equals floor(sum / d).
   // Evaluated only at elaboration.
   function automatic recip_table_type build_recip_table();
      recip_table_type   tbl;
      logic [NUM_W-1:0]  num;
      logic [NUM_W-1:0]  quo;
      logic [REM_W-1:0]  rem;
      tbl = '0;
      for (int d = 1; d <= WINDOW; d++) begin
         num = NUM_W'(1) << RECIP_SHIFT;
         num = num + NUM_W'(d - 1);
         rem = '0;
         quo = '0;
         for (int i = NUM_W - 1; i >= 0; i--) begin
            rem = {rem[REM_W-2:0], num[i]};
            if (rem >= REM_W'(d)) begin
               rem    = rem - REM_W'(d);
               quo[i] = 1'b1;
            end
         end
         tbl[d] = quo[RECIP_W-1:0];
      end
      return tbl;
   endfunction

   localparam recip_table_type RECIP_TABLE = build_recip_table();

endpackage

### rtl/slew_limited_moving_average.sv
// Slew-limited moving average over a ring of WINDOW samples. Each accepted sample
// passes in order through the step limiter, the update of the ring and running sum
// (the ring RAM read of the oldest entry takes the cycle before), the reciprocal
// multiply that divides by the fill count, and the load of the output register. The
// next sample is taken at the edge that loads the result, so only one sample is in
// the datapath at a time; a held result stalls the input once the following one is
// ready. The ring needs no clearing after reset, and max_step resets to its full range.
module slew_limited_moving_average (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [slma_pkg::DATA_W-1:0]  req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [slma_pkg::DATA_W-1:0]  rsp_filtered_value,
   input  logic                         csr_write_enable,
   input  logic [slma_pkg::DATA_W-1:0]  csr_write_data
);
   import slma_pkg::*;

   slma_cmd_type cmd;

   slma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   slma_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_sample         (req_sample),
      .rsp_filtered_value (rsp_filtered_value)
   );

`ifndef SYNTH
   // An accepted transaction walks through limit, update and multiply in order.
   a_sequence: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.limit_en ##1 cmd.update_en ##1 cmd.mult_en)
      else $error("processing sequence broken after accept");

   // A result is never loaded over one that is still held by a stalled receiver.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(rsp_valid && rsp_stall))
      else $error("result loaded over a pending result");

   // Inputs are not taken while an earlier transaction is still in the datapath.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> req_stall)
      else $error("input accepted while busy");
`endif

endmodule

### rtl/slma_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module slma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

### rtl/slma_div.sv
// Divides the running sum by the fill count through a reciprocal multiply.
// Depends on slma_pkg for sizes and the reciprocal table.
module slma_div (
   input  logic                         clock,
   input  logic                         start,
   input  logic [slma_pkg::SUM_W-1:0]   dividend,
   input  logic [slma_pkg::CNT_W-1:0]   divisor,
   output logic [slma_pkg::DATA_W-1:0]  quotient
);
   import slma_pkg::*;

   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(dividend) * PROD_W'(RECIP_TABLE[divisor]);

   always_ff @(posedge clock) begin
      if (start) begin
         product_ff <= product_in;
      end
   end

   assign quotient = product_ff[RECIP_SHIFT +: DATA_W];

endmodule

### rtl/slma_ctrl.sv
// Sequencing state machine and output valid for the slew-limited moving average.
// Depends on slma_pkg for the command struct.
module slma_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output slma_pkg::slma_cmd_type cmd
);
   import slma_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      LIMIT,
      UPDATE,
      MULT,
      DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // A new transaction can be taken in the same cycle the previous result is loaded.
   assign req_stall = !((state_ff == IDLE) || ((state_ff == DONE) && out_free));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd.accept    = accept;
      cmd.limit_en  = (state_ff == LIMIT);
      cmd.update_en = (state_ff == UPDATE);
      cmd.mult_en   = (state_ff == MULT);
      cmd.load      = (state_ff == DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= LIMIT;
               end
            end
            LIMIT:  state_ff <= UPDATE;
            UPDATE: state_ff <= MULT;
            MULT:   state_ff <= DONE;
            DONE: begin
               if (out_free) begin
                  state_ff <= accept ? LIMIT : IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/slma_dp.sv
// Datapath: step limiter, sample ring with running sum, divider and output register.
// Depends on slma_pkg, slma_ram and slma_div.
module slma_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  slma_pkg::slma_cmd_type       cmd,
   input  logic                         csr_write_enable,
   input  logic [slma_pkg::DATA_W-1:0]  csr_write_data,
   input  logic [slma_pkg::DATA_W-1:0]  req_sample,
   output logic [slma_pkg::DATA_W-1:0]  rsp_filtered_value
);
   import slma_pkg::*;

   logic [DATA_W-1:0] max_step_ff;
   logic [DATA_W-1:0] sample_ff;
   logic [DATA_W-1:0] last_output_ff;
   logic [DATA_W-1:0] limited_ff;
   logic [DATA_W-1:0] limited_in;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [CNT_W-1:0]  fill_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [DATA_W-1:0] rsp_value_ff;

   logic [DATA_W-1:0] old_entry;
   logic [DATA_W-1:0] removed;
   logic [DATA_W-1:0] quotient;
   logic [DATA_W-1:0] diff;
   logic [DATA_W-1:0] step_up;
   logic [DATA_W-1:0] step_down;
   logic              rising;
   logic              clamp;
   logic              full;

   // The clamped values lie between the previous output (reached when max_step is zero)
   // and the sample, short of the sample, so they never wrap where they are selected.
   always_comb begin
      rising     = sample_ff > last_output_ff;
      diff       = rising ? (sample_ff - last_output_ff) : (last_output_ff - sample_ff);
      clamp      = diff > max_step_ff;
      step_up    = last_output_ff + max_step_ff;
      step_down  = last_output_ff - max_step_ff;
      if ((last_output_ff == '0) || !clamp) begin
         limited_in = sample_ff;
      end else begin
         limited_in = rising ? step_up : step_down;
      end
   end

   // Once the ring is full the oldest entry leaves the sum as the new one enters.
   assign full    = (fill_ff == WINDOW_CNT);
   assign removed = full ? old_entry : '0;
   assign sum_in  = sum_ff - SUM_W'(removed) + SUM_W'(limited_ff);

   slma_ram #(
      .WIDTH (DATA_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock        (clock),
      .write_enable (cmd.update_en),
      .write_addr   (slot_ff),
      .write_data   (limited_ff),
      .read_enable  (cmd.limit_en),
      .read_addr    (slot_ff),
      .read_data    (old_entry)
   );

   slma_div u_div (
      .clock    (clock),
      .start    (cmd.mult_en),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff    <= MAX_STEP_RESET;
         last_output_ff <= '0;
         sum_ff         <= '0;
         fill_ff        <= '0;
         slot_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            max_step_ff <= csr_write_data;
         end
         if (cmd.update_en) begin
            sum_ff  <= sum_in;
            slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
            if (!full) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (cmd.load) begin
            last_output_ff <= quotient;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
      if (cmd.limit_en) begin
         limited_ff <= limited_in;
      end
      if (cmd.load) begin
         rsp_value_ff <= quotient;
      end
   end

   assign rsp_filtered_value = rsp_value_ff;

endmodule

### bench/testbench.sv
// Self-checking bench for the slew-limited moving average: drives samples and
// register writes, predicts each filtered value and checks every result transaction.
// Depends on rtl/slma_pkg.sv and rtl/slew_limited_moving_average.sv.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import slma_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [DATA_W-1:0]   req_sample = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DATA_W-1:0]   rsp_filtered_value;
   logic                csr_write_enable = 1'b0;
   logic [DATA_W-1:0]   csr_write_data = '0;

   // Bench copy of the filter state.
   logic [DATA_W-1:0]   step_limit = MAX_STEP_RESET;
   logic [DATA_W-1:0]   prev_filtered = '0;
   logic [DATA_W-1:0]   ring_model [WINDOW];
   logic [SUM_W-1:0]    sum_model = '0;
   logic [CNT_W-1:0]    fill_model = '0;
   logic [SLOT_W-1:0]   slot_model = '0;

   logic [DATA_W-1:0]   pending_samples [$];
   logic [DATA_W-1:0]   expected_filtered [$];

   int   error_count = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_requests = 0;
   int   hold_served = 0;
   bit   idle_on = 1'b1;

   slew_limited_moving_average DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #6 clock = ~clock;

   // Takes one sample into the model and returns the filtered value it yields.
   function automatic logic [DATA_W-1:0] next_filtered(input logic [DATA_W-1:0] sample);
      logic [DATA_W-1:0] limited;
      logic [DATA_W-1:0] result;
      limited = sample;
      if (prev_filtered != '0) begin
         if (sample > prev_filtered && sample - prev_filtered > step_limit)
            limited = prev_filtered + step_limit;
         else if (sample < prev_filtered && prev_filtered - sample > step_limit)
            limited = prev_filtered - step_limit;
      end
      if (fill_model < WINDOW_CNT) begin
         ring_model[slot_model] = limited;
         sum_model  = sum_model + SUM_W'(limited);
         fill_model = fill_model + 1'b1;
      end else begin
         sum_model = sum_model - SUM_W'(ring_model[slot_model]) + SUM_W'(limited);
         ring_model[slot_model] = limited;
      end
      slot_model = (slot_model == LAST_SLOT) ? '0 : slot_model + 1'b1;
      result = DATA_W'(sum_model / SUM_W'(fill_model));
      prev_filtered = result;
      return result;
   endfunction

   // Driver: a sample transaction completes when valid is high and stall is low.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_filtered.push_back(next_filtered(req_sample));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(1, 18) - 1;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_valid  <= 1'b1;
               req_sample <= pending_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure, with an occasional long hold-off on request.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         stall_left  = 149;
         rsp_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: compares each result transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_filtered.size() == 0) begin
            $error("filtered_value: expected none, actual %0d", rsp_filtered_value);
            error_count++;
         end else begin
            logic [DATA_W-1:0] want;
            want = expected_filtered.pop_front();
            if (rsp_filtered_value !== want) begin
               $error("filtered_value: expected %0d, actual %0d", want, rsp_filtered_value);
               error_count++;
            end
         end
      end
   end

   task automatic write_step_limit(input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      step_limit = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Holds off until every sample is in and every result is out, plus a margin.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || expected_filtered.size() != 0 || req_valid);
      repeat (6) @(negedge clock);
   endtask

   // Mostly a random walk, with full-range values, rail values and runs of zeros.
   task automatic queue_random(input int count, inout logic [DATA_W-1:0] walk);
      int pick;
      int delta;
      int next;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            walk = DATA_W'($urandom);
         end else if (pick < 26) begin
            walk = '0;
         end else if (pick < 31) begin
            walk = '1;
         end else if (pick < 33) begin
            repeat (WINDOW + 1) pending_samples.push_back('0);
            walk = '0;
         end else begin
            delta = $urandom_range(0, 4000) - 2000;
            next  = int'(walk) + delta;
            if (next < 0) next = 0;
            if (next > 65535) next = 65535;
            walk = DATA_W'(next);
         end
         pending_samples.push_back(walk);
      end
   endtask

   initial begin
      logic [DATA_W-1:0] walk;
      logic [DATA_W-1:0] phase_limit [10];
      walk = 16'd30000;
      phase_limit = '{16'd0, 16'd1, 16'hFFFF, 16'd7, 16'd250, 16'hFFFE,
                      16'h8000, 16'd40, 16'd3000, 16'hFFFF};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Full step range: pass-through from zero, rails and the slot wrap.
      write_step_limit(16'hFFFF);
      pending_samples = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF,
                          16'd0, 16'd12345, 16'd54321};
      wait_drained();
      // No step allowed at all: the output holds once it is nonzero.
      write_step_limit(16'd0);
      pending_samples = '{16'hFFFF, 16'd0, 16'd1};
      wait_drained();
      // Clamped rise and fall.
      write_step_limit(16'd100);
      pending_samples = '{16'hFFFF, 16'd0, 16'd5000, 16'd4950, 16'd10};
      wait_drained();
      // A genuine zero output lets the next sample through unlimited.
      write_step_limit(16'hFFFF);
      repeat (WINDOW) pending_samples.push_back('0);
      wait_drained();
      write_step_limit(16'd1);
      pending_samples.push_back(16'd40000);
      wait_drained();

      for (int p = 0; p < 10; p++) begin
         write_step_limit(phase_limit[p]);
         idle_on = (p % 3 != 2) && (p != 9);
         if (p == 4) hold_requests++;
         queue_random((p == 9) ? 50 : 70, walk);
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (error_count == 0 && expected_filtered.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

### sim.f
rtl/slma_pkg.sv
rtl/slma_ram.sv
rtl/slma_div.sv
rtl/slma_ctrl.sv
rtl/slma_dp.sv
rtl/slew_limited_moving_average.sv
bench/testbench.sv
